/* design/keyed_quantity_accumulator_defines.svh */
// assertion macros for the keyed quantity accumulator
`ifndef KEYED_QUANTITY_ACCUMULATOR_DEFINES_SVH
`define KEYED_QUANTITY_ACCUMULATOR_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define KQA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the next cycle
`define KQA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/kqa_pkg.sv */
// shared constants and types for the keyed quantity accumulator
`default_nettype none
package kqa_pkg;
  localparam int unsigned KeyW     = 31;
  localparam int unsigned AmtW     = 14;
  localparam int unsigned CountW   = 31;
  localparam int unsigned TotalW   = 40;
  localparam int unsigned DefBuckets = 4096;
  localparam int unsigned DefWays    = 4;

  // request passed from the front to the back through the queue
  typedef struct packed {
    logic [KeyW-1:0]        key;
    logic signed [AmtW-1:0] amount;
  } kqa_req_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_UPDATE
  } kqa_bk_state_e;
endpackage
`default_nettype wire

/* design/kqa_ram.sv */
// generic single-port-write, single-read ram with registered read data
`default_nettype none
module kqa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* design/kqa_front.sv */
// front part: input request capture into a two-entry queue
`default_nettype none
module kqa_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  kqa_pkg::kqa_req_t   in_req_i,
  output logic                q_valid_o,
  input  wire                 q_ready_i,
  output kqa_pkg::kqa_req_t   q_req_o
);
  import kqa_pkg::*;

  kqa_req_t   buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = buf_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // pointer and fill update
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_req_i;
    end
  end

`include "keyed_quantity_accumulator_defines.svh"
  `KQA_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue fill out of range")
  `KQA_ASSERT_NEXT(a_fill_push, push && !pop && cnt_q == 2'd0, cnt_q == 2'd1, "push lost")
  `KQA_ASSERT_NEXT(a_fill_pop, pop && !push && cnt_q == 2'd1, cnt_q == 2'd0, "pop lost")
endmodule
`default_nettype wire

/* design/kqa_back.sv */
// back part: bucket read, way compare, update and result register
`default_nettype none
module kqa_back #(
  parameter int unsigned Buckets = kqa_pkg::DefBuckets,
  parameter int unsigned Ways    = kqa_pkg::DefWays
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_valid_i,
  output logic                         q_ready_o,
  input  kqa_pkg::kqa_req_t            q_req_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [kqa_pkg::CountW-1:0]   entry_count_o,
  output logic [kqa_pkg::TotalW-1:0]   grand_total_o,
  output logic                         dropped_o
);
  import kqa_pkg::*;

  localparam int unsigned BW    = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned WayW  = KeyW + CountW;
  localparam int unsigned WidxW = (Ways > 1) ? $clog2(Ways) : 1;
  localparam logic [CountW:0] CountMax = {1'b0, {CountW{1'b1}}};
  localparam logic [TotalW+1:0] TotalMax = {2'b00, {TotalW{1'b1}}};

  kqa_bk_state_e state_q, state_d;
  kqa_req_t      req_q;
  logic [BW-1:0] bucket;
  logic [BW-1:0] clr_q, clr_d;
  logic [Ways-1:0] vld_rd, vld_wr_row;
  logic [Ways*WayW-1:0] row_rd, row_wr;
  logic          vld_we, row_we, rd_en;
  logic [BW-1:0] waddr, raddr;
  logic [TotalW-1:0] total_q, total_d;
  logic          hit, free_any;
  logic [WidxW-1:0] hit_w, free_w, sel_w;
  logic [CountW-1:0] old_c, new_c;
  logic signed [CountW+1:0] sum_c;
  logic signed [TotalW+1:0] sum_t;
  logic          res_drop;

  // bucket from the low key bits, the bucket count being a power of two
  assign bucket = q_req_i.key[BW-1:0];

  // valid bits and row store
  kqa_ram #(.Width(Ways), .Depth(Buckets)) u_vld (
    .clk_i, .we_i(vld_we), .waddr_i(waddr), .wdata_i(vld_wr_row),
    .re_i(rd_en), .raddr_i(raddr), .rdata_o(vld_rd));
  kqa_ram #(.Width(Ways*WayW), .Depth(Buckets)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(waddr), .wdata_i(row_wr),
    .re_i(rd_en), .raddr_i(raddr), .rdata_o(row_rd));

  // way compare and lowest free way
  always_comb begin
    hit = 1'b0; hit_w = '0; free_any = 1'b0; free_w = '0;
    for (int w = Ways-1; w >= 0; w--) begin
      if (vld_rd[w] && row_rd[w*WayW +: KeyW] == req_q.key) begin
        hit = 1'b1; hit_w = WidxW'(w);
      end
      if (!vld_rd[w]) begin
        free_any = 1'b1; free_w = WidxW'(w);
      end
    end
    sel_w  = hit ? hit_w : free_w;
    old_c  = hit ? row_rd[32'(hit_w)*WayW+KeyW +: CountW] : '0;
    sum_c  = $signed({2'b00, old_c}) + (CountW+2)'(req_q.amount);
    if (sum_c < 0) new_c = '0;
    else if (sum_c > $signed({1'b0, CountMax})) new_c = CountMax[CountW-1:0];
    else new_c = sum_c[CountW-1:0];
    sum_t  = $signed({2'b00, total_q}) + (TotalW+2)'($signed({1'b0, new_c}))
           - (TotalW+2)'($signed({1'b0, old_c}));
    res_drop = !hit && !free_any;
    vld_wr_row = vld_rd;
    vld_wr_row[sel_w] = 1'b1;
    if (state_q == BK_CLEAR) vld_wr_row = '0;
    row_wr = row_rd;
    row_wr[32'(sel_w)*WayW +: WayW] = {new_c, req_q.key};
  end

  // sequencer: clearing pass, read, update
  always_comb begin
    state_d = state_q; clr_d = clr_q; q_ready_o = 1'b0; rd_en = 1'b0;
    vld_we = 1'b0; row_we = 1'b0; waddr = req_q.key[BW-1:0]; raddr = bucket;
    total_d = total_q;
    unique case (state_q)
      BK_CLEAR: begin
        vld_we = 1'b1; waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == BW'(Buckets-1)) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!out_valid_o || out_ready_i) begin
          q_ready_o = 1'b1;
          if (q_valid_i) begin
            rd_en = 1'b1; state_d = BK_READ;
          end
        end
      end
      BK_READ: state_d = BK_UPDATE;
      BK_UPDATE: begin
        if (!res_drop) begin
          vld_we = 1'b1; row_we = 1'b1;
          if (sum_t < 0) total_d = '0;
          else if (sum_t > $signed(TotalMax)) total_d = TotalMax[TotalW-1:0];
          else total_d = sum_t[TotalW-1:0];
        end
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR; clr_q <= '0; total_q <= '0; out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; total_q <= total_d;
      if (state_q == BK_UPDATE) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (q_ready_o && q_valid_i) req_q <= q_req_i;
    if (state_q == BK_UPDATE) begin
      entry_count_o <= res_drop ? '0 : new_c;
      grand_total_o <= total_d;
      dropped_o     <= res_drop;
    end
  end

`include "keyed_quantity_accumulator_defines.svh"
  `KQA_ASSERT_NEXT(a_read_update, state_q == BK_READ, state_q == BK_UPDATE, "no update after read")
  `KQA_ASSERT_NEXT(a_result, state_q == BK_UPDATE, out_valid_o, "result not raised")
  `KQA_ASSERT(a_no_take_clr, !(state_q == BK_CLEAR && q_ready_o), "request taken while clearing")
endmodule
`default_nettype wire

/* design/keyed_quantity_accumulator.sv */
// Keyed quantity accumulator: a set-associative count store of BUCKETS
// buckets by WAYS ways; BUCKETS is a power of two and the bucket is taken
// from the low key bits. The back part holds a request through accept with
// bucket read issued, read data return, and compare and write back, so it
// takes no new request until write back is done and any pending result is
// taken; a result is valid the cycle after write back. This pacing is set
// by the read-modify-write of the bucket row memory; a two-entry queue lets
// input requests arrive while the back part works. After reset a clearing
// pass over all BUCKETS buckets empties the valid bits before the first
// request is taken.
// A key that is new to a full bucket is dropped, reported by the dropped flag.
`default_nettype none
module keyed_quantity_accumulator #(
  parameter int unsigned BUCKETS = kqa_pkg::DefBuckets,
  parameter int unsigned WAYS    = kqa_pkg::DefWays
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [47:0]  s_axis_tdata,  // item_key [30:0], amount [44:31], zero fill
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,  // entry_count [30:0], grand_total [70:31], zero fill
  output logic        m_axis_tuser   // dropped [0]
);
  import kqa_pkg::*;

  kqa_req_t in_req, q_req;
  logic     q_valid, q_ready, dropped;
  logic [CountW-1:0] entry_count;
  logic [TotalW-1:0] grand_total;

  assign in_req.key    = s_axis_tdata[KeyW-1:0];
  assign in_req.amount = s_axis_tdata[KeyW+AmtW-1:KeyW];
  assign m_axis_tdata  = {1'b0, grand_total, entry_count};
  assign m_axis_tuser  = dropped;

  kqa_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req));

  kqa_back #(.Buckets(BUCKETS), .Ways(WAYS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .entry_count_o(entry_count), .grand_total_o(grand_total), .dropped_o(dropped));
endmodule
`default_nettype wire

/* verif/keyed_quantity_accumulator_tb.sv */
// self-checking testbench for the keyed quantity accumulator
`default_nettype none
module keyed_quantity_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kqa_pkg::*;

  localparam int unsigned NBUCKETS = DefBuckets;
  localparam int unsigned NWAYS    = DefWays;
  localparam longint unsigned CountMax = 64'h7FFF_FFFF;
  localparam longint unsigned TotalMax = 64'hFF_FFFF_FFFF;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [KeyW-1:0]        key;
    logic signed [AmtW-1:0] amount;
  } qty_req_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [TotalW-1:0] total;
    logic              dropped;
  } qty_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tuser;

  keyed_quantity_accumulator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // item_key [30:0], amount [44:31], zero fill
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),  // entry_count [30:0], grand_total [70:31], zero fill
    .m_axis_tuser  (m_axis_tuser)   // dropped [0]
  );

  always #2 clk_i = ~clk_i;

  // shadow of the count store
  bit              shadow_used  [NBUCKETS*NWAYS];
  logic [KeyW-1:0] shadow_key   [NBUCKETS*NWAYS];
  longint          shadow_count [NBUCKETS*NWAYS];
  longint          shadow_total = 0;

  qty_req_t pending_reqs[$];
  qty_res_t expected_counts[$];
  int       mismatches = 0;
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_send;
  int       idle_cycles = 0;
  logic [KeyW-1:0] key_pool[$];

  // apply one request to the shadow store and return the predicted response
  function automatic qty_res_t apply_quantity(qty_req_t r);
    qty_res_t res;
    int base;
    int hit;
    int freew;
    int idx;
    longint oldc;
    longint newc;
    longint t;
    base = (r.key % NBUCKETS) * NWAYS;
    hit = -1;
    freew = -1;
    oldc = 0;
    for (int w = 0; w < NWAYS; w++) begin
      if (shadow_used[base+w]) begin
        if (hit < 0 && shadow_key[base+w] == r.key) hit = w;
      end else if (freew < 0) begin
        freew = w;
      end
    end
    res = '0;
    if (hit < 0 && freew < 0) begin
      res.total = TotalW'(shadow_total);
      res.dropped = 1'b1;
      return res;
    end
    if (hit >= 0) begin
      idx = base + hit;
      oldc = shadow_count[idx];
    end else begin
      idx = base + freew;
      shadow_used[idx] = 1'b1;
      shadow_key[idx] = r.key;
    end
    newc = oldc + longint'(r.amount);
    if (newc < 0) newc = 0;
    if (newc > longint'(CountMax)) newc = longint'(CountMax);
    shadow_count[idx] = newc;
    t = shadow_total + (newc - oldc);
    if (t < 0) t = 0;
    if (t > longint'(TotalMax)) t = longint'(TotalMax);
    shadow_total = t;
    res.count = CountW'(newc);
    res.total = TotalW'(t);
    return res;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    logic [KeyW-1:0] k;
    case ($urandom_range(0, 9)) inside
      [0:4]: k = key_pool[$urandom_range(0, key_pool.size()-1)];
      [5:6]: k = {19'($urandom_range(0, 7)), 12'h05a};  // crowd one bucket
      default: k = KeyW'($urandom);
    endcase
    if (key_pool.size() < 40) key_pool.push_back(k);
    return k;
  endfunction

  function automatic logic signed [AmtW-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return AmtW'(-14'sd4096 + $urandom_range(0, 8191));
      1: return AmtW'($urandom);
      2: return AmtW'(14'sd8191 - $urandom_range(0, 3));
      3: return AmtW'(14'sh2000 + $urandom_range(0, 3));
      default: return AmtW'($urandom_range(0, 4096));
    endcase
  endfunction

  // driver: present queued requests, predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_counts.push_back(apply_quantity(pending_reqs.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current request
      end else if (pending_reqs.size() > 0 && !hold_send
                   && ($urandom_range(0, 99) >= send_idle_pct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, pending_reqs[0].amount, pending_reqs[0].key};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each response with the oldest prediction
  always @(posedge clk_i) begin
    qty_res_t got;
    qty_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.count = m_axis_tdata[30:0];
        got.total = m_axis_tdata[70:31];
        got.dropped = m_axis_tuser;
        if (expected_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", m_axis_tdata);
        end else begin
          want = expected_counts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: count exp %0d got %0d, total exp %0d got %0d,",
                       want.count, got.count, want.total, got.total,
                       " drop exp %b got %b", want.dropped, got.dropped);
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on accepted traffic, allowing for the clearing pass
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (pending_reqs.size() == 0 && expected_counts.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("keyed_quantity_accumulator_tb: errors");
        $finish;
      end
    end
  end

  task automatic push_req(logic [KeyW-1:0] k, logic signed [AmtW-1:0] a);
    qty_req_t r;
    r.key = k;
    r.amount = a;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_counts.size() > 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_send = 1'b0;
    key_pool.push_back(31'h0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, negative first amount, clamp, full bucket, repeated maximum amount
    push_req(31'h0, 14'sd4096);
    push_req(31'h0, 14'sh2000);
    push_req(31'h7fff_ffff, -14'sd5);
    push_req(31'h7fff_ffff, 14'sd8191);
    push_req(31'h4000_0000, 14'sd1);
    push_req(31'h2aaa_a000, -14'sd1);
    push_req(31'h5555_5000, 14'sd100);
    push_req(31'h0000_1000, 14'sd7);   // new key, bucket 0 already full
    push_req(31'h0000_2000, 14'sd9);   // new key, bucket full
    push_req(31'h0, 14'sd3);
    push_req(31'h4000_0000, -14'sd4096);
    push_req(31'h7fff_ffff, 14'sd0);
    for (int i = 0; i < 6; i++) push_req(31'h1234_5fff, 14'sd8191);
    drain();

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int i = 0; i < 160; i++) push_req(pick_key(), pick_amount());
      if (ph == 1) begin
        // pause the sender until every response is in
        while (pending_reqs.size() > 80) @(posedge clk_i);
        hold_send = 1'b1;
        while (expected_counts.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_counts.size() == 0)
      $display("keyed_quantity_accumulator_tb: clean");
    else
      $display("keyed_quantity_accumulator_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+design
design/kqa_pkg.sv
design/kqa_ram.sv
design/kqa_front.sv
design/kqa_back.sv
design/keyed_quantity_accumulator.sv
verif/keyed_quantity_accumulator_tb.sv
